[hw/rtl/psc_pkg.sv]
// shared types and constants for the pretrigger snapshot capture block
package psc_pkg;

  localparam int RingDepth  = 512;
  localparam int SnapDepth  = 2048;
  localparam int BackPoints = 400;
  localparam int RingAw     = $clog2(RingDepth);
  localparam int SnapAw     = $clog2(SnapDepth);
  localparam int RingCw     = $clog2(RingDepth + 1);
  localparam int SnapCw     = $clog2(SnapDepth + 1);
  localparam int PtW        = 160;

  typedef enum logic [2:0] {
    KIND_EVENT  = 3'd0,
    KIND_POLL   = 3'd1,
    KIND_ARM    = 3'd2,
    KIND_DISARM = 3'd3,
    KIND_CLEAR  = 3'd4,
    KIND_FDONE  = 3'd5,
    KIND_READ   = 3'd6,
    KIND_NOP    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    REG_CAPTURE_MS = 3'd0,
    REG_HOLD_MS    = 3'd1,
    REG_START_RPM  = 3'd2,
    REG_LOW_RPM    = 3'd3,
    REG_FILL_TRIG  = 3'd4,
    REG_DROP_FILL  = 3'd5,
    REG_STAGE_TO   = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BACK_RD,
    ST_BACK_WR,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_POLL_END,
    ST_READ_WAIT,
    ST_READ_CAP,
    ST_OUT
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic       take;       // latch input word
    logic       ev_write;   // write event into ring
    logic       do_arm;
    logic       do_disarm;
    logic       do_clear;
    logic       do_fdone;
    logic       poll_pre;   // staging / trigger evaluation
    logic       back_init;  // set up backtrack copy
    logic       ring_rd;    // issue ring read at current address
    logic       back_wr;    // store backtrack point
    logic       drain_wr;   // store drained point
    logic       poll_end;   // recording end / hold end checks
    logic       snap_rd;    // issue store read
    logic       rd_cap;     // capture store read data
  } psc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    kind_e kind;
    logic  trig;
    logic  back_more;
    logic  drain_more;
    logic  recording;
    logic  read_ok;
  } psc_sts_t;

endpackage

[hw/rtl/psc_ctrl.sv]
// controller state machine for the pretrigger snapshot capture block
module psc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  psc_pkg::psc_sts_t sts_i,
  output psc_pkg::psc_cmd_t cmd_o
);

  psc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = psc_pkg::ST_DECIDE;
      end
      psc_pkg::ST_DECIDE: begin
        case (sts_i.kind)
          psc_pkg::KIND_EVENT: begin
            state_d = sts_i.recording ? psc_pkg::ST_DRAIN_RD : psc_pkg::ST_OUT;
          end
          psc_pkg::KIND_POLL: begin
            if (sts_i.trig) state_d = psc_pkg::ST_BACK_RD;
            else if (sts_i.recording) state_d = psc_pkg::ST_DRAIN_RD;
            else state_d = psc_pkg::ST_POLL_END;
          end
          psc_pkg::KIND_READ: state_d = psc_pkg::ST_READ_WAIT;
          default: state_d = psc_pkg::ST_OUT;
        endcase
      end
      psc_pkg::ST_BACK_RD: begin
        state_d = sts_i.back_more ? psc_pkg::ST_BACK_WR : psc_pkg::ST_DRAIN_RD;
      end
      psc_pkg::ST_BACK_WR: state_d = psc_pkg::ST_BACK_RD;
      psc_pkg::ST_DRAIN_RD: begin
        if (sts_i.drain_more) state_d = psc_pkg::ST_DRAIN_WR;
        else if (sts_i.kind == psc_pkg::KIND_POLL) state_d = psc_pkg::ST_POLL_END;
        else state_d = psc_pkg::ST_OUT;
      end
      psc_pkg::ST_DRAIN_WR: state_d = psc_pkg::ST_DRAIN_RD;
      psc_pkg::ST_POLL_END: state_d = psc_pkg::ST_OUT;
      psc_pkg::ST_READ_WAIT: state_d = psc_pkg::ST_READ_CAP;
      psc_pkg::ST_READ_CAP: state_d = psc_pkg::ST_OUT;
      psc_pkg::ST_OUT: begin
        if (out_ready_i) state_d = psc_pkg::ST_IDLE;
      end
      default: state_d = psc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      psc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      psc_pkg::ST_DECIDE: begin
        case (sts_i.kind)
          psc_pkg::KIND_EVENT:  cmd_o.ev_write  = 1'b1;
          psc_pkg::KIND_POLL: begin
            cmd_o.poll_pre  = 1'b1;
            cmd_o.back_init = sts_i.trig;
          end
          psc_pkg::KIND_ARM:    cmd_o.do_arm    = 1'b1;
          psc_pkg::KIND_DISARM: cmd_o.do_disarm = 1'b1;
          psc_pkg::KIND_CLEAR:  cmd_o.do_clear  = 1'b1;
          psc_pkg::KIND_FDONE:  cmd_o.do_fdone  = 1'b1;
          psc_pkg::KIND_READ:   cmd_o.snap_rd   = 1'b1;
          default: ;
        endcase
      end
      psc_pkg::ST_BACK_RD:  cmd_o.ring_rd  = sts_i.back_more;
      psc_pkg::ST_BACK_WR:  cmd_o.back_wr  = 1'b1;
      psc_pkg::ST_DRAIN_RD: cmd_o.ring_rd  = sts_i.drain_more;
      psc_pkg::ST_DRAIN_WR: cmd_o.drain_wr = 1'b1;
      psc_pkg::ST_POLL_END: cmd_o.poll_end = 1'b1;
      psc_pkg::ST_READ_CAP: cmd_o.rd_cap   = 1'b1;
      psc_pkg::ST_OUT:      out_valid_o    = 1'b1;
      default: ;
    endcase
  end

endmodule

[hw/rtl/psc_dp.sv]
// datapath: ring, snapshot store, phase flags, registers and result word
module psc_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psc_pkg::psc_cmd_t cmd_i,
  output psc_pkg::psc_sts_t sts_o,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [2:0]        kind_i,
  input  logic [31:0]       time_us_i,
  input  logic signed [63:0] position_count_i,
  input  logic [31:0]       index_count_i,
  input  logic signed [31:0] event_speed_i,
  input  logic [19:0]       poll_speed_i,
  input  logic [31:0]       now_ms_i,
  input  logic [10:0]       read_addr_i,
  output logic [31:0]       rd_time_o,
  output logic signed [63:0] rd_count_o,
  output logic [31:0]       rd_index_o,
  output logic signed [31:0] rd_speed_o,
  output logic [11:0]       stored_count_o,
  output logic [9:0]        fill_level_o,
  output logic              is_recording_o,
  output logic              is_alive_o,
  output logic              is_busy_o,
  output logic              is_finished_o,
  output logic              done_pulse_o
);

  localparam int RAw = psc_pkg::RingAw;
  localparam int SAw = psc_pkg::SnapAw;
  localparam int RCw = psc_pkg::RingCw;
  localparam int SCw = psc_pkg::SnapCw;
  localparam logic [RCw-1:0] RingFull = RCw'(psc_pkg::RingDepth);
  localparam logic [SCw-1:0] SnapFull = SCw'(psc_pkg::SnapDepth);
  localparam logic [RCw-1:0] BackN    = RCw'(psc_pkg::BackPoints > psc_pkg::RingDepth ?
                                             psc_pkg::RingDepth : psc_pkg::BackPoints);

  // configuration
  logic [31:0] capture_ms_q, hold_ms_q, stage_to_q;
  logic [19:0] start_rpm_q, low_rpm_q;
  logic [9:0]  fill_trig_q, drop_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_ms_q <= 32'd2000;
      hold_ms_q    <= 32'd2000;
      start_rpm_q  <= 20'd10;
      low_rpm_q    <= 20'd5;
      fill_trig_q  <= 10'd120;
      drop_fill_q  <= 10'd40;
      stage_to_q   <= 32'd200;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psc_pkg::REG_CAPTURE_MS: capture_ms_q <= cfg_data_i;
        psc_pkg::REG_HOLD_MS:    hold_ms_q    <= cfg_data_i;
        psc_pkg::REG_START_RPM:  start_rpm_q  <= cfg_data_i[19:0];
        psc_pkg::REG_LOW_RPM:    low_rpm_q    <= cfg_data_i[19:0];
        psc_pkg::REG_FILL_TRIG:  fill_trig_q  <= cfg_data_i[9:0];
        psc_pkg::REG_DROP_FILL:  drop_fill_q  <= cfg_data_i[9:0];
        psc_pkg::REG_STAGE_TO:   stage_to_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word latch
  logic [2:0]  kind_q;
  logic [31:0] tus_q, ix_q, sp_q, ms_q;
  logic [63:0] cnt_q;
  logic [19:0] rpm_q;
  logic [SAw-1:0] raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= psc_pkg::KIND_NOP;
    end else if (cmd_i.take) begin
      kind_q <= kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      tus_q   <= time_us_i;
      cnt_q   <= position_count_i;
      ix_q    <= index_count_i;
      sp_q    <= event_speed_i;
      rpm_q   <= poll_speed_i;
      ms_q    <= now_ms_i;
      raddr_q <= read_addr_i[SAw-1:0];
    end
  end

  // control state
  logic [RAw-1:0] wr_ptr_q;
  logic [RCw-1:0] rfill_q;
  logic [31:0]    rorigin_q;
  logic           rstarted_q;
  logic [SCw-1:0] sfill_q;
  logic [31:0]    sorigin_q;
  logic           armed_q, staging_q, rec_q, alive_q, pulse_q;
  logic [31:0]    stage_start_q, phase_start_q;
  logic [RCw-1:0] back_left_q;
  logic [RAw-1:0] back_addr_q;
  logic           back_first_q;
  logic [31:0]    base_q, last_t_q;

  // ring memory
  logic [psc_pkg::PtW-1:0] ring_mem [psc_pkg::RingDepth];
  logic [psc_pkg::PtW-1:0] ring_rdata_q;
  logic [RAw-1:0]          ring_raddr;
  logic                    ring_we;
  logic [psc_pkg::PtW-1:0] ring_wdata;

  assign ring_we    = cmd_i.ev_write;
  assign ring_wdata = {tus_q - (rstarted_q ? rorigin_q : tus_q), cnt_q, ix_q, sp_q};
  // backtrack walks its own address, the flush always reads the oldest point
  assign ring_raddr = sts_o.back_more ? back_addr_q : wr_ptr_q - rfill_q[RAw-1:0];

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[wr_ptr_q] <= ring_wdata;
    if (cmd_i.ring_rd) ring_rdata_q <= ring_mem[ring_raddr];
  end

  // snapshot store
  logic [psc_pkg::PtW-1:0] snap_mem [psc_pkg::SnapDepth];
  logic [psc_pkg::PtW-1:0] snap_rdata_q;
  logic                    snap_we;
  logic [psc_pkg::PtW-1:0] snap_wdata;
  logic [31:0]             rt_raw, rt_back, rt_drain;

  assign rt_raw   = ring_rdata_q[159:128];
  assign rt_back  = rt_raw - (back_first_q ? rt_raw : base_q);
  assign rt_drain = (sfill_q != '0 && (rt_raw - sorigin_q) <= last_t_q) ?
                    last_t_q + 32'd1 : rt_raw - sorigin_q;
  assign snap_we  = (cmd_i.back_wr || cmd_i.drain_wr) && sfill_q < SnapFull;
  assign snap_wdata = {cmd_i.back_wr ? rt_back : rt_drain, ring_rdata_q[127:0]};

  always_ff @(posedge clk_i) begin
    if (snap_we) snap_mem[sfill_q[SAw-1:0]] <= snap_wdata;
    if (cmd_i.snap_rd) snap_rdata_q <= snap_mem[raddr_q];
  end

  // trigger evaluation in the decide step
  logic stage_now;
  logic [31:0] stage_base;
  assign stage_now  = !rec_q && !alive_q && armed_q && rpm_q > start_rpm_q;
  assign stage_base = staging_q ? stage_start_q : ms_q;
  assign sts_o.trig = stage_now && (rfill_q >= RCw'(fill_trig_q) ||
                      (ms_q - stage_base) >= stage_to_q ||
                      (rpm_q < low_rpm_q && rfill_q >= RCw'(drop_fill_q)));

  assign sts_o.kind       = psc_pkg::kind_e'(kind_q);
  assign sts_o.back_more  = back_left_q != '0;
  assign sts_o.drain_more = sfill_q < SnapFull && rfill_q != '0;
  assign sts_o.recording  = rec_q;
  assign sts_o.read_ok    = {1'b0, raddr_q} < sfill_q;

  logic rd_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q      <= '0;
      rfill_q       <= '0;
      rorigin_q     <= '0;
      rstarted_q    <= 1'b0;
      sfill_q       <= '0;
      sorigin_q     <= '0;
      armed_q       <= 1'b0;
      staging_q     <= 1'b0;
      rec_q         <= 1'b0;
      alive_q       <= 1'b0;
      pulse_q       <= 1'b0;
      stage_start_q <= '0;
      phase_start_q <= '0;
      back_left_q   <= '0;
      back_addr_q   <= '0;
      back_first_q  <= 1'b0;
      base_q        <= '0;
      last_t_q      <= '0;
      rd_ok_q       <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        pulse_q <= 1'b0;
        rd_ok_q <= 1'b0;
      end
      if (cmd_i.ev_write) begin
        if (!rstarted_q) begin
          rorigin_q  <= tus_q;
          rstarted_q <= 1'b1;
        end
        wr_ptr_q <= wr_ptr_q + 1'b1;
        if (rfill_q < RingFull) rfill_q <= rfill_q + 1'b1;
      end
      if (cmd_i.do_arm) armed_q <= 1'b1;
      if (cmd_i.do_disarm) armed_q <= 1'b0;
      if (cmd_i.do_clear) begin
        sfill_q    <= '0;
        wr_ptr_q   <= '0;
        rfill_q    <= '0;
        rstarted_q <= 1'b0;
        sorigin_q  <= '0;
        rec_q      <= 1'b0;
        alive_q    <= 1'b0;
        staging_q  <= 1'b0;
      end
      if (cmd_i.do_fdone) begin
        rec_q         <= 1'b0;
        alive_q       <= 1'b1;
        phase_start_q <= '0;
      end
      if (cmd_i.poll_pre) begin
        if (sts_o.trig) begin
          staging_q     <= 1'b0;
          rec_q         <= 1'b1;
          phase_start_q <= ms_q;
        end else if (stage_now) begin
          if (!staging_q) begin
            staging_q     <= 1'b1;
            stage_start_q <= ms_q;
          end
        end else if (!rec_q && !alive_q && armed_q) begin
          staging_q <= 1'b0;
        end
      end
      if (cmd_i.back_init) begin
        // newest points up to the backtrack depth, oldest first
        back_left_q  <= rfill_q < BackN ? rfill_q : BackN;
        back_addr_q  <= wr_ptr_q - (rfill_q < BackN ? rfill_q[RAw-1:0] : BackN[RAw-1:0]);
        back_first_q <= 1'b1;
        rfill_q      <= '0;
      end
      if (cmd_i.ring_rd && back_left_q != '0) begin
        back_addr_q <= back_addr_q + 1'b1;
        back_left_q <= back_left_q - 1'b1;
      end
      if (cmd_i.back_wr) begin
        if (back_first_q) begin
          base_q    <= rt_raw;
          sorigin_q <= rt_raw;
        end
        back_first_q <= 1'b0;
        if (snap_we) begin
          sfill_q  <= sfill_q + 1'b1;
          last_t_q <= rt_back;
        end
      end
      if (cmd_i.drain_wr) begin
        sfill_q  <= sfill_q + 1'b1;
        last_t_q <= rt_drain;
        rfill_q  <= rfill_q - 1'b1;
      end
      if (cmd_i.poll_end) begin
        if (rec_q && (sfill_q >= SnapFull || ms_q - phase_start_q >= capture_ms_q)) begin
          rec_q         <= 1'b0;
          phase_start_q <= ms_q;
          // a zero hold ends the alive phase on the same poll
          if (hold_ms_q == '0) begin
            alive_q <= 1'b0;
            armed_q <= 1'b0;
            pulse_q <= sfill_q != '0;
          end else begin
            alive_q <= 1'b1;
          end
        end else if (alive_q && !rec_q && ms_q - phase_start_q >= hold_ms_q) begin
          alive_q <= 1'b0;
          armed_q <= 1'b0;
          pulse_q <= sfill_q != '0;
        end
      end
      if (cmd_i.snap_rd) rd_ok_q <= sts_o.read_ok;
    end
  end

  logic [psc_pkg::PtW-1:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else if (cmd_i.take) begin
      rd_q <= '0;
    end else if (cmd_i.rd_cap && rd_ok_q) begin
      rd_q <= snap_rdata_q;
    end
  end

  assign rd_time_o      = rd_q[159:128];
  assign rd_count_o     = rd_q[127:64];
  assign rd_index_o     = rd_q[63:32];
  assign rd_speed_o     = rd_q[31:0];
  assign stored_count_o = 12'(sfill_q);
  assign fill_level_o   = 10'(rfill_q);
  assign is_recording_o = rec_q;
  assign is_alive_o     = alive_q;
  assign is_busy_o      = armed_q || staging_q || rec_q || alive_q;
  assign is_finished_o  = !rec_q && !alive_q && sfill_q != '0;
  assign done_pulse_o   = pulse_q;

endmodule

[hw/rtl/pretrigger_snapshot_capture.sv]
// Pretrigger snapshot capture top level. Every input word produces one result
// word; a word taken up while idle passes the decide state and then the steps
// below before its result is offered. Arm, disarm, clear, force done, unused
// kinds and an event outside recording go straight to the output; a read adds
// a wait and a capture step (registered store read). An event while recording
// adds the flush of its point into the store. A poll adds the end checks, and
// while recording first the flush of each point. A triggering poll first
// copies each backtrack point (up to 400); the copy empties the ring, so
// nothing is flushed after it. The copy and flush loops move one point per
// registered ring read followed by one store write. The next word is taken
// the cycle after the result is taken.
module pretrigger_snapshot_capture (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  input  logic [31:0]       time_us_i,
  input  logic signed [63:0] position_count_i,
  input  logic [31:0]       index_count_i,
  input  logic signed [31:0] event_speed_i,
  input  logic [19:0]       poll_speed_i,
  input  logic [31:0]       now_ms_i,
  input  logic [10:0]       read_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       rd_time_o,
  output logic signed [63:0] rd_count_o,
  output logic [31:0]       rd_index_o,
  output logic signed [31:0] rd_speed_o,
  output logic [11:0]       stored_count_o,
  output logic [9:0]        fill_level_o,
  output logic              is_recording_o,
  output logic              is_alive_o,
  output logic              is_busy_o,
  output logic              is_finished_o,
  output logic              done_pulse_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  psc_pkg::psc_cmd_t cmd;
  psc_pkg::psc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  psc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  psc_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .kind_i,
    .time_us_i,
    .position_count_i,
    .index_count_i,
    .event_speed_i,
    .poll_speed_i,
    .now_ms_i,
    .read_addr_i,
    .rd_time_o,
    .rd_count_o,
    .rd_index_o,
    .rd_speed_o,
    .stored_count_o,
    .fill_level_o,
    .is_recording_o,
    .is_alive_o,
    .is_busy_o,
    .is_finished_o,
    .done_pulse_o
  );

endmodule

[hw/rtl/psc_checker.sv]
// port-level checks for the pretrigger snapshot capture block
module psc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_recording_o,
  input logic        is_alive_o,
  input logic        is_busy_o,
  input logic        is_finished_o,
  input logic        done_pulse_o,
  input logic [11:0] stored_count_o
);

  // one word in flight at a time
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  a_rec_alive_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_recording_o && is_alive_o)) else $error("recording and alive");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (is_recording_o || is_alive_o) |-> is_busy_o) else $error("busy flag");

  a_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_finished_o |-> stored_count_o != 12'd0) else $error("finished empty");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_pulse_o |-> is_finished_o) else $error("done without data");

endmodule

bind pretrigger_snapshot_capture psc_checker u_psc_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .is_recording_o,
  .is_alive_o,
  .is_busy_o,
  .is_finished_o,
  .done_pulse_o,
  .stored_count_o
);
